### rtl/core/vector_rotate_about_point_defines.svh
// Assertion macros for the rotate-about-point RTL.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef VECTOR_ROTATE_ABOUT_POINT_DEFINES_SVH
`define VECTOR_ROTATE_ABOUT_POINT_DEFINES_SVH

// Checked only while out of reset.
`define VRAP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every clock edge, reset included.
`define VRAP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### rtl/core/vrap_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the rotate-about-point block: widths, angle units,
// CORDIC arctangent table and gain. No dependencies.
package vrap_pkg;

    localparam int COORD_BITS_DEF   = 24;
    localparam int CORDIC_STEPS_DEF = 20;

    localparam int ANGLE_BITS     = 17;
    localparam int ANGLE_RED_BITS = ANGLE_BITS + 1;
    localparam int FULL_TURN      = 46080;
    localparam int HALF_TURN      = 23040;
    localparam int QUARTER_TURN   = 11520;
    localparam int ANGLE_SHIFT    = 9;
    localparam int Z_BITS         = 25;

    // Guard bits plus coordinate bits always add up to this.
    localparam int SCALED_BITS = 60;
    localparam int XY_BITS     = 64;

    localparam int          GAIN_BITS = 32;
    localparam logic [31:0] GAIN_Q32  = 32'd2608131496;

    localparam int ATAN_BITS = 22;
    localparam int TABLE_LEN = 32;

    // atan(2^-i) in 1/65536 degree, rounded to nearest.
    localparam logic [ATAN_BITS-1:0] ATAN_TABLE [TABLE_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0
    };

endpackage

### rtl/core/vrap_item_if.sv
`timescale 1ns / 1ps
// Input channel of the rotate-about-point block: point, pivot and angle.
// Depends on vrap_pkg.
interface vrap_item_if #(
    parameter int COORD_BITS = vrap_pkg::COORD_BITS_DEF
);
    logic                                  valid;
    logic                                  ready;
    logic signed [COORD_BITS-1:0]          point_x;
    logic signed [COORD_BITS-1:0]          point_y;
    logic signed [COORD_BITS-1:0]          pivot_x;
    logic signed [COORD_BITS-1:0]          pivot_y;
    logic signed [vrap_pkg::ANGLE_BITS-1:0] turn_angle;

    modport source (
        output valid, point_x, point_y, pivot_x, pivot_y, turn_angle,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, pivot_x, pivot_y, turn_angle,
        output ready
    );
endinterface

### rtl/core/vrap_result_if.sv
`timescale 1ns / 1ps
// Output channel of the rotate-about-point block: rotated point and overflow.
// Depends on vrap_pkg.
interface vrap_result_if #(
    parameter int COORD_BITS = vrap_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] rotated_x;
    logic signed [COORD_BITS-1:0] rotated_y;
    logic                         overflow;

    modport source (
        output valid, rotated_x, rotated_y, overflow,
        input  ready
    );

    modport sink (
        input  valid, rotated_x, rotated_y, overflow,
        output ready
    );
endinterface

### rtl/core/vector_rotate_about_point.sv
`timescale 1ns / 1ps
// Rotates a point about a pivot with a pipelined CORDIC, one beat per cycle unless stalled.
// Depends on vrap_pkg, vrap_item_if, vrap_result_if and the assertion header.
//
// Each input beat carries a point, a pivot and an angle in 1/128 degree; the
// output beat carries the point turned about the pivot by that angle (positive
// turns from +x toward +y), saturated to the coordinate range, with overflow
// set when either coordinate was clipped. The block is a fully pipelined
// datapath and takes a new beat in every cycle while it is not stalled; each
// beat passes through one register stage per CORDIC step plus two front
// stages (offset and angle reduction, quadrant fold) and five back stages
// (magnitude, gain multiply, two adds for rounding, descale) before the
// output register. The whole pipeline holds when a finished result waits
// and the consumer is not ready, so nothing is lost or repeated; ready on
// the input therefore follows ready on the output whenever the output
// register is full. No state is kept between beats.
`include "vector_rotate_about_point_defines.svh"

module vector_rotate_about_point #(
    parameter int COORD_BITS   = vrap_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STEPS = vrap_pkg::CORDIC_STEPS_DEF
) (
    input logic           clk,
    input logic           rst_n,
    vrap_item_if.sink     item,
    vrap_result_if.source result
);

    // Offsets are scaled up by GUARD bits so the CORDIC keeps fractional bits.
    localparam int GUARD    = vrap_pkg::SCALED_BITS - COORD_BITS;
    localparam int XY_BITS  = vrap_pkg::XY_BITS;
    localparam int MAG_BITS = XY_BITS - 1;
    localparam int HI_BITS  = MAG_BITS - vrap_pkg::GAIN_BITS;
    localparam int LO_BITS  = vrap_pkg::GAIN_BITS;
    localparam int PH_BITS  = HI_BITS + vrap_pkg::GAIN_BITS;
    localparam int PL_BITS  = LO_BITS + vrap_pkg::GAIN_BITS;
    localparam int T_BITS   = PL_BITS + 1 - vrap_pkg::GAIN_BITS;
    localparam int D_BITS   = COORD_BITS + 1;
    localparam int R_BITS   = COORD_BITS + 2;
    localparam int RS_BITS  = COORD_BITS + 3;
    localparam int SUM_BITS = COORD_BITS + 4;
    localparam int AR_BITS  = vrap_pkg::ANGLE_RED_BITS;
    localparam int Z_BITS   = vrap_pkg::Z_BITS;
    localparam int A_BITS   = vrap_pkg::ATAN_BITS;
    // Stage indices: 0 offset/reduce, 1 fold, 2..STEPS+1 CORDIC,
    // STEPS+2..STEPS+6 gain and descale, STEPS+7 output register.
    localparam int G0   = CORDIC_STEPS + 2;
    localparam int G4   = CORDIC_STEPS + 6;
    localparam int PIPE = CORDIC_STEPS + 7;
    localparam int NUM_G = G4 - G0 + 1;

    localparam logic signed [AR_BITS-1:0] FULL_A    = AR_BITS'(vrap_pkg::FULL_TURN);
    localparam logic signed [AR_BITS-1:0] HALF_A    = AR_BITS'(vrap_pkg::HALF_TURN);
    localparam logic signed [AR_BITS-1:0] QUARTER_A = AR_BITS'(vrap_pkg::QUARTER_TURN);
    localparam logic signed [Z_BITS-1:0]  Z_QUARTER =
        Z_BITS'(vrap_pkg::QUARTER_TURN * (2 ** vrap_pkg::ANGLE_SHIFT));

    localparam logic signed [SUM_BITS-1:0] SUM_MAX =
        {{(SUM_BITS - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN =
        {{(SUM_BITS - COORD_BITS + 1){1'b1}}, {(COORD_BITS - 1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] OUT_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] OUT_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

    localparam logic [PL_BITS:0]  GAIN_HALF  = (PL_BITS + 1)'(1) << (vrap_pkg::GAIN_BITS - 1);
    localparam logic [XY_BITS:0]  GUARD_HALF = (XY_BITS + 1)'(1) << (GUARD - 1);

    // Pipeline control: every stage moves together.
    logic adv;
    logic vld_reg [0:PIPE];

    // Pivot travels alongside the item; lane 0 is x, lane 1 is y.
    logic signed [COORD_BITS-1:0] pv_reg [0:G4][0:1];

    // Stage 0: offset and angle reduced to [-180, 180) degrees.
    logic signed [D_BITS-1:0]  d_next   [0:1];
    logic signed [D_BITS-1:0]  d_reg    [0:1];
    logic signed [AR_BITS-1:0] ang_w;
    logic signed [AR_BITS-1:0] ang_m;
    logic signed [AR_BITS-1:0] ang_next;
    logic signed [AR_BITS-1:0] ang_a_reg;

    // Stage 1: quadrant fold, scale-up, CORDIC entry.
    logic                      fold;
    logic signed [AR_BITS-1:0] ang_f;
    logic signed [D_BITS-1:0]  df      [0:1];
    logic signed [XY_BITS-1:0] x_b_next;
    logic signed [XY_BITS-1:0] y_b_next;
    logic signed [Z_BITS-1:0]  z_b_next;

    // CORDIC stages.
    logic signed [XY_BITS-1:0] x_reg  [0:CORDIC_STEPS];
    logic signed [XY_BITS-1:0] y_reg  [0:CORDIC_STEPS];
    logic signed [Z_BITS-1:0]  z_reg  [0:CORDIC_STEPS];
    logic signed [XY_BITS-1:0] x_next [0:CORDIC_STEPS-1];
    logic signed [XY_BITS-1:0] y_next [0:CORDIC_STEPS-1];
    logic signed [Z_BITS-1:0]  z_next [0:CORDIC_STEPS-1];

    // Gain and descale stages, per lane.
    logic signed [XY_BITS-1:0] fin      [0:1];
    logic [XY_BITS-1:0]        mag_w    [0:1];
    logic [1:0]                neg_reg  [0:NUM_G-1];
    logic [MAG_BITS-1:0]       mag_reg  [0:1];
    logic [PH_BITS-1:0]        ph_reg   [0:1];
    logic [PL_BITS-1:0]        pl_reg   [0:1];
    logic [PL_BITS:0]          pl_rnd   [0:1];
    logic [PH_BITS-1:0]        ph2_reg  [0:1];
    logic [T_BITS-1:0]         t_reg    [0:1];
    logic [XY_BITS-1:0]        p_reg    [0:1];
    logic [XY_BITS:0]          p_rnd    [0:1];
    logic [R_BITS-1:0]         r_reg    [0:1];

    // Output stage.
    logic signed [RS_BITS-1:0]    rs       [0:1];
    logic signed [SUM_BITS-1:0]   sum      [0:1];
    logic signed [COORD_BITS-1:0] rot_next [0:1];
    logic [1:0]                   sat;
    logic signed [COORD_BITS-1:0] rot_reg  [0:1];
    logic                         ovf_reg;

    assign adv        = !vld_reg[PIPE] || result.ready;
    assign item.ready = adv;

    assign result.valid     = vld_reg[PIPE];
    assign result.rotated_x = rot_reg[0];
    assign result.rotated_y = rot_reg[1];
    assign result.overflow  = ovf_reg;

    // Offset is exact in one extra bit. The angle is first taken modulo a
    // full turn (truncating, so the sign is kept), then into a half-open
    // half turn on either side of zero.
    always_comb
    begin
        d_next[0] = D_BITS'(item.point_x) - D_BITS'(item.pivot_x);
        d_next[1] = D_BITS'(item.point_y) - D_BITS'(item.pivot_y);
        ang_w     = AR_BITS'(item.turn_angle);
        if (ang_w >= FULL_A)
        begin
            ang_m = ang_w - FULL_A;
        end
        else if (ang_w <= -FULL_A)
        begin
            ang_m = ang_w + FULL_A;
        end
        else
        begin
            ang_m = ang_w;
        end
        if (ang_m >= HALF_A)
        begin
            ang_next = ang_m - FULL_A;
        end
        else if (ang_m < -HALF_A)
        begin
            ang_next = ang_m + FULL_A;
        end
        else
        begin
            ang_next = ang_m;
        end
    end

    // Beyond a quarter turn either way the offset is negated and a half turn
    // is taken off, so the CORDIC only sees angles within +-90 degrees.
    always_comb
    begin
        fold = (ang_a_reg > QUARTER_A) || (ang_a_reg < -QUARTER_A);
        if (ang_a_reg > QUARTER_A)
        begin
            ang_f = ang_a_reg - HALF_A;
        end
        else if (ang_a_reg < -QUARTER_A)
        begin
            ang_f = ang_a_reg + HALF_A;
        end
        else
        begin
            ang_f = ang_a_reg;
        end
        df[0]    = fold ? -d_reg[0] : d_reg[0];
        df[1]    = fold ? -d_reg[1] : d_reg[1];
        x_b_next = XY_BITS'(df[0]) <<< GUARD;
        y_b_next = XY_BITS'(df[1]) <<< GUARD;
        z_b_next = Z_BITS'(ang_f) <<< vrap_pkg::ANGLE_SHIFT;
    end

    // One micro-rotation per stage; the shifts are arithmetic (floor).
    always_comb
    begin
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            if (!z_reg[k][Z_BITS-1])
            begin
                x_next[k] = x_reg[k] - (y_reg[k] >>> k);
                y_next[k] = y_reg[k] + (x_reg[k] >>> k);
                z_next[k] = z_reg[k]
                    - signed'({{(Z_BITS - A_BITS){1'b0}}, vrap_pkg::ATAN_TABLE[k]});
            end
            else
            begin
                x_next[k] = x_reg[k] + (y_reg[k] >>> k);
                y_next[k] = y_reg[k] - (x_reg[k] >>> k);
                z_next[k] = z_reg[k]
                    + signed'({{(Z_BITS - A_BITS){1'b0}}, vrap_pkg::ATAN_TABLE[k]});
            end
        end
    end

    // Gain compensation works on the magnitude so that rounding is to
    // nearest with ties away from zero; the sign rides along separately.
    // The gain product is split in a high and a low partial product.
    always_comb
    begin
        fin[0] = x_reg[CORDIC_STEPS];
        fin[1] = y_reg[CORDIC_STEPS];
        for (int l = 0; l < 2; l++)
        begin
            mag_w[l]  = fin[l][XY_BITS-1] ? XY_BITS'(-fin[l]) : XY_BITS'(fin[l]);
            pl_rnd[l] = (PL_BITS + 1)'(pl_reg[l]) + GAIN_HALF;
            p_rnd[l]  = (XY_BITS + 1)'(p_reg[l]) + GUARD_HALF;
            rs[l]     = neg_reg[NUM_G-1][l] ? -signed'({1'b0, r_reg[l]})
                                            : signed'({1'b0, r_reg[l]});
            sum[l]    = SUM_BITS'(rs[l]) + SUM_BITS'(pv_reg[G4][l]);
            if (sum[l] > SUM_MAX)
            begin
                rot_next[l] = OUT_MAX;
                sat[l]      = 1'b1;
            end
            else if (sum[l] < SUM_MIN)
            begin
                rot_next[l] = OUT_MIN;
                sat[l]      = 1'b1;
            end
            else
            begin
                rot_next[l] = sum[l][COORD_BITS-1:0];
                sat[l]      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= PIPE; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= item.valid;
            for (int s = 1; s <= PIPE; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pv_reg[0][0] <= item.pivot_x;
            pv_reg[0][1] <= item.pivot_y;
            for (int s = 1; s <= G4; s++)
            begin
                pv_reg[s] <= pv_reg[s-1];
            end

            d_reg     <= d_next;
            ang_a_reg <= ang_next;

            x_reg[0] <= x_b_next;
            y_reg[0] <= y_b_next;
            z_reg[0] <= z_b_next;
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                x_reg[k+1] <= x_next[k];
                y_reg[k+1] <= y_next[k];
                z_reg[k+1] <= z_next[k];
            end

            neg_reg[0] <= {fin[1][XY_BITS-1], fin[0][XY_BITS-1]};
            for (int g = 1; g < NUM_G; g++)
            begin
                neg_reg[g] <= neg_reg[g-1];
            end

            for (int l = 0; l < 2; l++)
            begin
                mag_reg[l] <= mag_w[l][MAG_BITS-1:0];
                ph_reg[l]  <= PH_BITS'(mag_reg[l][MAG_BITS-1:LO_BITS])
                            * PH_BITS'(vrap_pkg::GAIN_Q32);
                pl_reg[l]  <= PL_BITS'(mag_reg[l][LO_BITS-1:0])
                            * PL_BITS'(vrap_pkg::GAIN_Q32);
                ph2_reg[l] <= ph_reg[l];
                t_reg[l]   <= pl_rnd[l][PL_BITS:vrap_pkg::GAIN_BITS];
                p_reg[l]   <= XY_BITS'(ph2_reg[l]) + XY_BITS'(t_reg[l]);
                r_reg[l]   <= p_rnd[l][GUARD+R_BITS-1:GUARD];
            end

            rot_reg <= rot_next;
            ovf_reg <= |sat;
        end
    end

    // An overflow flag always comes with at least one clipped coordinate.
    `VRAP_ASSERT(a_ovf_clipped, result.valid && result.overflow |-> (result.rotated_x == OUT_MAX) || (result.rotated_x == OUT_MIN) || (result.rotated_y == OUT_MAX) || (result.rotated_y == OUT_MIN), "overflow set without a saturated coordinate")
    // Angle reduction lands in the half-open half turn around zero.
    `VRAP_ASSERT(a_ang_reduced, vld_reg[0] |-> (ang_a_reg >= -HALF_A) && (ang_a_reg < HALF_A), "reduced angle out of range")
    // After the fold the CORDIC never sees more than a quarter turn.
    `VRAP_ASSERT(a_z_folded, vld_reg[1] |-> (z_reg[0] <= Z_QUARTER) && (z_reg[0] >= -Z_QUARTER), "CORDIC entry angle beyond a quarter turn")
    // Nothing is offered downstream while reset is held.
    `VRAP_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |-> !result.valid, "result valid during reset")

endmodule
